// ----- design/bdq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_pkg: shared types and constants of the bounded deque
// Command and status codes, sequencer states and fixed field widths.
// ----------------------------------------------------------------------------
package bdq_pkg;

	// Default geometry
	localparam int DEPTH_DEF  = 16;
	localparam int DATA_W_DEF = 32;

	// Fixed field widths
	localparam int FUNC_W   = 3;
	localparam int WORD_W   = 32;
	localparam int POS_W    = 8;
	localparam int STATUS_W = 3;
	localparam int OCOUNT_W = 5;

	// Search reports at most this many matches
	localparam int MAX_HITS = 16;
	localparam int HIT_W    = $clog2(MAX_HITS + 1);

	typedef enum logic [FUNC_W-1:0] {
		F_PUSH_BACK  = 3'd0,
		F_PUSH_FRONT = 3'd1,
		F_POP_FRONT  = 3'd2,
		F_POP_BACK   = 3'd3,
		F_REMOVE     = 3'd4,
		F_SEARCH     = 3'd5,
		F_READ       = 3'd6,
		F_SIZE       = 3'd7
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 3'd0,
		ST_EMPTY    = 3'd1,
		ST_FULL     = 3'd2,
		ST_RANGE    = 3'd3,
		ST_NOTFOUND = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_READ,
		S_WALK
	} state_t;

endpackage

// ----- design/bounded_deque_with_value_remove.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_deque_with_value_remove: ring-buffer deque with remove by value
// Commands push, pop, remove, search, read and size on a DEPTH-entry ring.
// ----------------------------------------------------------------------------
// Usage:
//  A command beat (func, value, position) is taken at a rising edge with
//  start high and busy low. busy stays high while the command runs.
//  Results come out as beats on status, result_word, entry_count and last,
//  each marked by done for exactly one cycle; last flags the final beat of
//  the command. The receiver cannot stall, so every beat is taken as shown.
//  Remove and search walk the held entries through the single memory read
//  port, one entry a cycle, into one shared comparator; remove compacts in
//  place through the write port on the same pass. Search gives one beat per
//  match (at most 16), or one not-found beat. The next command is taken in
//  the cycle its predecessor's final beat is shown.
//  Reset empties the deque (front pointer and count to zero); the entry
//  memory is not cleared and its contents are never used outside the held range.
// ----------------------------------------------------------------------------
module bounded_deque_with_value_remove
	import bdq_pkg::*;
#(
	parameter int DEPTH  = DEPTH_DEF,
	parameter int DATA_W = DATA_W_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [FUNC_W-1:0]          func,
	input  logic signed [WORD_W-1:0]   value,
	input  logic [POS_W-1:0]           position,
	output logic                       done,
	output logic [STATUS_W-1:0]        status,
	output logic signed [WORD_W-1:0]   result_word,
	output logic [OCOUNT_W-1:0]        entry_count,
	output logic                       last
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	// Ring slot of the entry at offset ofs from the front
	function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] base,
		input logic [CNT_W-1:0] ofs);
		logic [CNT_W:0] sum;
		sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(ofs);
		if (sum >= (CNT_W + 1)'(DEPTH)) begin
			sum = sum - (CNT_W + 1)'(DEPTH);
		end
		return sum[PTR_W-1:0];
	endfunction

	state_t              state_q, state_d;
	func_t               func_q;
	logic [DATA_W-1:0]   value_q;
	logic [POS_W-1:0]    pos_q;

	logic [PTR_W-1:0]    front_q, front_d;
	logic [CNT_W-1:0]    count_q, count_d;
	logic [CNT_W-1:0]    idx_q, idx_d;
	logic [CNT_W-1:0]    n_q, n_d;
	logic                rdv_s1, rdv_d;
	logic [CNT_W-1:0]    rdidx_s1, rdidx_d;
	logic                pend_vld_q, pend_vld_d;
	logic [CNT_W-1:0]    pend_idx_q, pend_idx_d;
	logic [HIT_W-1:0]    hit_q, hit_d;

	logic                done_q, emit_d;
	status_t             status_q, ost_d;
	logic [WORD_W-1:0]   word_q, oword_d;
	logic [OCOUNT_W-1:0] ocount_q;
	logic                last_q, olast_d;

	logic [DATA_W-1:0]   mem_q [DEPTH];
	logic [DATA_W-1:0]   rdata_q;
	logic [PTR_W-1:0]    rd_addr, wr_addr, front_inc, front_dec;
	logic [DATA_W-1:0]   wr_data;
	logic                we;

	logic                full, empty, hit, walk_end, pos_oor;

	// Shared compare and status terms
	assign full      = (count_q == CNT_W'(DEPTH));
	assign empty     = (count_q == '0);
	assign hit       = (rdata_q == value_q);
	assign walk_end  = (idx_q == count_q) && !rdv_s1;
	assign pos_oor   = (WORD_W'(pos_q) >= WORD_W'(count_q));
	assign front_inc = slot_of(front_q, CNT_W'(1));
	assign front_dec = (front_q == '0) ? PTR_W'(DEPTH - 1) : PTR_W'(front_q - 1'b1);

	// Sequencer next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) state_d = S_EXEC;
			end
			S_EXEC: begin
				case (func_q)
					F_REMOVE: state_d = empty ? S_IDLE : S_WALK;
					F_SEARCH: state_d = S_WALK;
					F_READ:   state_d = S_READ;
					default:  state_d = S_IDLE;
				endcase
			end
			S_READ: state_d = S_IDLE;
			S_WALK: begin
				if (walk_end) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Datapath control and result beats
	always_comb begin
		rd_addr    = slot_of(front_q, idx_q);
		we         = 1'b0;
		wr_addr    = slot_of(front_q, n_q);
		wr_data    = value_q;
		front_d    = front_q;
		count_d    = count_q;
		idx_d      = idx_q;
		n_d        = n_q;
		rdv_d      = 1'b0;
		rdidx_d    = idx_q;
		pend_vld_d = pend_vld_q;
		pend_idx_d = pend_idx_q;
		hit_d      = hit_q;
		emit_d     = 1'b0;
		ost_d      = ST_OK;
		oword_d    = '0;
		olast_d    = 1'b1;
		case (state_q)
			S_EXEC: begin
				idx_d      = '0;
				n_d        = '0;
				pend_vld_d = 1'b0;
				hit_d      = '0;
				case (func_q)
					F_PUSH_BACK: begin
						emit_d = 1'b1;
						if (full) begin
							ost_d = ST_FULL;
						end else begin
							we      = 1'b1;
							wr_addr = slot_of(front_q, count_q);
							count_d = count_q + 1'b1;
						end
					end
					F_PUSH_FRONT: begin
						emit_d = 1'b1;
						if (full) begin
							ost_d = ST_FULL;
						end else begin
							we      = 1'b1;
							wr_addr = front_dec;
							front_d = front_dec;
							count_d = count_q + 1'b1;
						end
					end
					F_POP_FRONT: begin
						emit_d = 1'b1;
						if (empty) begin
							ost_d = ST_EMPTY;
						end else begin
							front_d = front_inc;
							count_d = count_q - 1'b1;
						end
					end
					F_POP_BACK: begin
						emit_d = 1'b1;
						if (empty) begin
							ost_d = ST_EMPTY;
						end else begin
							count_d = count_q - 1'b1;
						end
					end
					F_REMOVE: begin
						if (empty) begin
							emit_d = 1'b1;
							ost_d  = ST_EMPTY;
						end
					end
					F_SEARCH: begin
					end
					F_READ: begin
						rd_addr = slot_of(front_q, CNT_W'(pos_q));
					end
					default: begin
						emit_d = 1'b1;
					end
				endcase
			end
			S_READ: begin
				emit_d = 1'b1;
				if (pos_oor) begin
					ost_d = ST_RANGE;
				end else begin
					oword_d = WORD_W'(rdata_q);
				end
			end
			S_WALK: begin
				// Issue the read of the next held entry
				if (idx_q < count_q) begin
					rd_addr = slot_of(front_q, idx_q);
					rdv_d   = 1'b1;
					rdidx_d = idx_q;
					idx_d   = idx_q + 1'b1;
				end
				// Compare the entry read last cycle
				if (rdv_s1) begin
					if (func_q == F_REMOVE) begin
						if (!hit) begin
							we      = 1'b1;
							wr_addr = slot_of(front_q, n_q);
							wr_data = rdata_q;
							n_d     = n_q + 1'b1;
						end
					end else if (hit && (hit_q < HIT_W'(MAX_HITS))) begin
						if (pend_vld_q) begin
							emit_d  = 1'b1;
							oword_d = WORD_W'(pend_idx_q);
							olast_d = 1'b0;
						end
						pend_vld_d = 1'b1;
						pend_idx_d = rdidx_s1;
						hit_d      = hit_q + 1'b1;
					end
				end
				// Close the pass
				if (walk_end) begin
					emit_d = 1'b1;
					if (func_q == F_REMOVE) begin
						count_d = n_q;
					end else if (pend_vld_q) begin
						oword_d = WORD_W'(pend_idx_q);
					end else begin
						ost_d = ST_NOTFOUND;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			front_q    <= '0;
			count_q    <= '0;
			idx_q      <= '0;
			n_q        <= '0;
			rdv_s1     <= 1'b0;
			pend_vld_q <= 1'b0;
			hit_q      <= '0;
			done_q     <= 1'b0;
		end else begin
			state_q    <= state_d;
			front_q    <= front_d;
			count_q    <= count_d;
			idx_q      <= idx_d;
			n_q        <= n_d;
			rdv_s1     <= rdv_d;
			pend_vld_q <= pend_vld_d;
			hit_q      <= hit_d;
			done_q     <= emit_d;
		end
	end

	// Command capture and result payload
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			func_q  <= func_t'(func);
			value_q <= DATA_W'($unsigned(value));
			pos_q   <= position;
		end
		rdidx_s1   <= rdidx_d;
		pend_idx_q <= pend_idx_d;
		if (emit_d) begin
			status_q <= ost_d;
			word_q   <= oword_d;
			ocount_q <= OCOUNT_W'(count_d);
			last_q   <= olast_d;
		end
	end

	// Entry memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) mem_q[wr_addr] <= wr_data;
		rdata_q <= mem_q[rd_addr];
	end

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign status      = status_q;
	assign result_word = $signed(word_q);
	assign entry_count = ocount_q;
	assign last        = last_q;

	// Checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("held count above depth");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q != S_IDLE))
		else $error("result beat without a running command");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == S_EXEC))
		else $error("accepted command not dispatched");

	a_compact: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |-> (n_q <= idx_q))
		else $error("compaction write ahead of read");

	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> (done_q && last_q))
		else $error("command ended without a final beat");

endmodule

// ----- tb/sv/bdq_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_checker: scoreboard for the bounded deque
// Watches the command and result channels, keeps its own copy of the ring,
// works out the beats every accepted command must give and compares each
// result beat against the oldest one still due.
// ----------------------------------------------------------------------------
module bdq_checker
	import bdq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic                     busy,
	input  logic [FUNC_W-1:0]        func,
	input  logic [WORD_W-1:0]        value,
	input  logic [POS_W-1:0]         position,
	input  logic                     done,
	input  logic [STATUS_W-1:0]      status,
	input  logic [WORD_W-1:0]        result_word,
	input  logic [OCOUNT_W-1:0]      entry_count,
	input  logic                     last,
	output int unsigned              mismatch_total,
	output int unsigned              outstanding
);

	typedef struct packed {
		status_t             st;
		logic [WORD_W-1:0]   word;
		logic [OCOUNT_W-1:0] cnt;
		logic                fin;
	} deque_beat_t;

	// Shadow copy of the deque
	logic [WORD_W-1:0] ring [DEPTH];
	int                front_slot;
	int                fill;

	deque_beat_t       due_beats [$];
	deque_beat_t       oldest_due;
	int unsigned       bad_beats;

	function automatic deque_beat_t make_beat(status_t s, logic [WORD_W-1:0] w, logic f);
		make_beat.st   = s;
		make_beat.word = w;
		make_beat.cnt  = fill[OCOUNT_W-1:0];
		make_beat.fin  = f;
	endfunction

	// Append one beat to the tail of the due list
	function automatic void add_due(input deque_beat_t b);
		due_beats = {due_beats, b};
	endfunction

	// Apply one command to the shadow deque and queue the beats it must give
	task automatic run_command(input logic [FUNC_W-1:0] f, input logic [WORD_W-1:0] v,
			input logic [POS_W-1:0] p);
		logic [WORD_W-1:0] kept [$];
		int                hits [$];
		int                i;
		case (func_t'(f))
			F_PUSH_BACK, F_PUSH_FRONT: begin
				if (fill >= DEPTH) begin
					add_due(make_beat(ST_FULL, '0, 1'b1));
				end else begin
					if (func_t'(f) == F_PUSH_BACK) begin
						ring[(front_slot + fill) % DEPTH] = v;
					end else begin
						front_slot = (front_slot + DEPTH - 1) % DEPTH;
						ring[front_slot] = v;
					end
					fill++;
					add_due(make_beat(ST_OK, '0, 1'b1));
				end
			end
			F_POP_FRONT, F_POP_BACK: begin
				if (fill == 0) begin
					add_due(make_beat(ST_EMPTY, '0, 1'b1));
				end else begin
					if (func_t'(f) == F_POP_FRONT)
						front_slot = (front_slot + 1) % DEPTH;
					fill--;
					add_due(make_beat(ST_OK, '0, 1'b1));
				end
			end
			F_REMOVE: begin
				if (fill == 0) begin
					add_due(make_beat(ST_EMPTY, '0, 1'b1));
				end else begin
					// compact the survivors toward the front, order kept
					for (i = 0; i < fill; i++)
						if (ring[(front_slot + i) % DEPTH] != v)
							kept = {kept, ring[(front_slot + i) % DEPTH]};
					for (i = 0; i < kept.size(); i++)
						ring[(front_slot + i) % DEPTH] = kept[i];
					fill = kept.size();
					add_due(make_beat(ST_OK, '0, 1'b1));
				end
			end
			F_SEARCH: begin
				for (i = 0; i < fill; i++)
					if (ring[(front_slot + i) % DEPTH] == v && hits.size() < MAX_HITS)
						hits = {hits, i};
				if (hits.size() == 0) begin
					add_due(make_beat(ST_NOTFOUND, '0, 1'b1));
				end else begin
					for (i = 0; i < hits.size(); i++)
						add_due(make_beat(ST_OK, hits[i], (i == hits.size() - 1)));
				end
			end
			F_READ: begin
				if (int'(p) >= fill)
					add_due(make_beat(ST_RANGE, '0, 1'b1));
				else
					add_due(make_beat(ST_OK,
						ring[(front_slot + int'(p)) % DEPTH], 1'b1));
			end
			default: begin
				add_due(make_beat(ST_OK, '0, 1'b1));
			end
		endcase
	endtask

	// Check result beats first, then predict the command taken at this edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_slot = 0;
			fill       = 0;
			bad_beats  = 0;
			due_beats.delete();
			mismatch_total <= 0;
			outstanding    <= 0;
		end else begin
			if (done) begin
				if (due_beats.size() == 0) begin
					bad_beats++;
					if (bad_beats <= 10)
						$display("%0t: unexpected beat status=%0d word=%h count=%0d last=%b",
							$realtime, status, result_word, entry_count, last);
				end else begin
					oldest_due = due_beats[0];
					due_beats.delete(0);
					if (status !== oldest_due.st || result_word !== oldest_due.word ||
							entry_count !== oldest_due.cnt || last !== oldest_due.fin) begin
						bad_beats++;
						if (bad_beats <= 10) begin
							$write("%0t: beat mismatch exp status=%0d word=%h count=%0d last=%b",
								$realtime, oldest_due.st, oldest_due.word, oldest_due.cnt,
								oldest_due.fin);
							$display(", got status=%0d word=%h count=%0d last=%b",
								status, result_word, entry_count, last);
						end
					end
				end
			end
			if (start && !busy)
				run_command(func, value, position);
			mismatch_total <= bad_beats;
			outstanding    <= due_beats.size();
		end
	end

endmodule

// ----- tb/sv/tb_bounded_deque_with_value_remove.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bounded_deque_with_value_remove: command stimulus for the bounded deque
// Runs a directed pass over the empty, error and wrap cases, then random
// phases that fill, drain or mix the deque from small value pools so that
// duplicates, full refusals and long search hit lists occur. A checker
// instance scores every result beat; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_bounded_deque_with_value_remove;
	import bdq_pkg::*;

	localparam int STALL_LIMIT = 1000;
	localparam int PHASES      = 11;
	localparam int PHASE_LEN   = 28;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [FUNC_W-1:0]   func;
	logic [WORD_W-1:0]   value;
	logic [POS_W-1:0]    position;
	logic                done;
	logic [STATUS_W-1:0] status;
	logic [WORD_W-1:0]   result_word;
	logic [OCOUNT_W-1:0] entry_count;
	logic                last;

	int unsigned         mismatch_total;
	int unsigned         outstanding;
	int unsigned         quiet_cycles;
	bit                  gaps_on;
	logic [WORD_W-1:0]   word_pool [$];

	bounded_deque_with_value_remove dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.func        (func),
		.value       (value),
		.position    (position),
		.done        (done),
		.status      (status),
		.result_word (result_word),
		.entry_count (entry_count),
		.last        (last)
	);

	bdq_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.func           (func),
		.value          (value),
		.position       (position),
		.done           (done),
		.status         (status),
		.result_word    (result_word),
		.entry_count    (entry_count),
		.last           (last),
		.mismatch_total (mismatch_total),
		.outstanding    (outstanding)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Abort when neither a command nor a result beat moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("tb_bounded_deque_with_value_remove: done, errors");
				$finish;
			end
		end
	end

	// Present one command beat and hold it until taken
	task automatic issue(input func_t f, input logic [WORD_W-1:0] v,
			input logic [POS_W-1:0] p);
		while (gaps_on && $urandom_range(0, 99) < 17) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start    <= 1'b1;
		func     <= f;
		value    <= v;
		position <= p;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	function automatic logic [WORD_W-1:0] pick_word();
		if ($urandom_range(0, 99) < 75)
			return word_pool[$urandom_range(0, word_pool.size() - 1)];
		return $urandom();
	endfunction

	function automatic logic [POS_W-1:0] pick_pos();
		if ($urandom_range(0, 99) < 80)
			return POS_W'($urandom_range(0, 17));
		return POS_W'($urandom_range(0, 255));
	endfunction

	// Draw a fresh pool of one to four words, extremes now and then
	task automatic new_pool(input int n);
		word_pool.delete();
		repeat (n) begin
			case ($urandom_range(0, 7))
				0: word_pool = {word_pool, 32'h8000_0000};
				1: word_pool = {word_pool, 32'h7FFF_FFFF};
				2: word_pool = {word_pool, 32'hFFFF_FFFF};
				3: word_pool = {word_pool, 32'h0000_0000};
				default: word_pool = {word_pool, WORD_W'($urandom())};
			endcase
		end
	endtask

	function automatic func_t pick_func(input int mode);
		int r;
		r = $urandom_range(0, 99);
		case (mode)
			// fill: mostly pushes, probe the contents
			0: begin
				if (r < 38) return F_PUSH_BACK;
				if (r < 75) return F_PUSH_FRONT;
				if (r < 85) return F_SEARCH;
				if (r < 93) return F_READ;
				return F_SIZE;
			end
			// drain: pops and removes
			1: begin
				if (r < 22) return F_POP_FRONT;
				if (r < 44) return F_POP_BACK;
				if (r < 70) return F_REMOVE;
				if (r < 82) return F_SEARCH;
				if (r < 92) return F_READ;
				return F_SIZE;
			end
			default: return func_t'($urandom_range(0, 7));
		endcase
	endfunction

	initial begin
		int mode;
		clk      = 1'b0;
		arst_n   = 1'b0;
		start    = 1'b0;
		func     = F_SIZE;
		value    = '0;
		position = '0;
		gaps_on  = 1'b1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty deque: every error path
		issue(F_POP_FRONT, 32'h0, 8'd0);
		issue(F_POP_BACK, 32'h0, 8'd0);
		issue(F_REMOVE, 32'h1, 8'd0);
		issue(F_SEARCH, 32'h1, 8'd0);
		issue(F_READ, 32'h0, 8'd0);
		issue(F_SIZE, 32'h0, 8'd0);
		// Extremes from both ends, wrapping the front pointer
		issue(F_PUSH_BACK, 32'h7FFF_FFFF, 8'd0);
		issue(F_PUSH_FRONT, 32'h8000_0000, 8'd0);
		issue(F_PUSH_BACK, 32'hFFFF_FFFF, 8'd0);
		issue(F_PUSH_FRONT, 32'h0000_0000, 8'd0);
		issue(F_PUSH_BACK, 32'h7FFF_FFFF, 8'd0);
		// Several hits, then no hit
		issue(F_SEARCH, 32'h7FFF_FFFF, 8'd0);
		issue(F_SEARCH, 32'h5, 8'd0);
		// Reads: past the count, first, last held, one past the end
		issue(F_READ, 32'h0, 8'd255);
		issue(F_READ, 32'h0, 8'd0);
		issue(F_READ, 32'h0, 8'd4);
		issue(F_READ, 32'h0, 8'd5);
		// Remove with matches, then with none
		issue(F_REMOVE, 32'h7FFF_FFFF, 8'd0);
		issue(F_REMOVE, 32'h0001_2345, 8'd0);
		issue(F_POP_FRONT, 32'h0, 8'd0);
		issue(F_POP_BACK, 32'h0, 8'd0);
		issue(F_SIZE, 32'h0, 8'd0);
		issue(F_POP_FRONT, 32'h0, 8'd0);

		// Random phases; the first fills from one word for a full hit list
		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph == 0) begin
				mode = 0;
				new_pool(1);
			end else begin
				mode = $urandom_range(0, 2);
				new_pool($urandom_range(1, 4));
			end
			gaps_on = !(ph == 5 || ph == 6);
			repeat (PHASE_LEN)
				issue(pick_func(mode), pick_word(), pick_pos());
		end
		start   <= 1'b0;
		gaps_on = 1'b1;

		// Drain, then let the last command settle
		while (outstanding != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
		if (mismatch_total == 0 && outstanding == 0)
			$display("tb_bounded_deque_with_value_remove: done, clean");
		else
			$display("tb_bounded_deque_with_value_remove: done, errors");
		$finish;
	end

endmodule
